// ----- rtl/radix_integer_to_grouped_ascii_defines.svh -----
// assertion macros for the radix to grouped ascii converter
`ifndef RADIX_INTEGER_TO_GROUPED_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_GROUPED_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
// implication or plain property, checked out of reset
`define RIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ria assertion failed");
// condition that must never be seen
`define RIA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ria forbidden condition seen");
`else
`define RIA_ASSERT(lbl, prop)
`define RIA_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/ria_pkg.sv -----
// shared types, constants and helpers for the radix to grouped ascii converter
package ria_pkg;

  localparam int DefValueWidth = 32;
  localparam int DefMaxDigits  = 32;
  localparam int RadixW        = 6;
  localparam int DigitW        = 6;
  localparam int CharW         = 8;

  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixDec   = 6'd10;

  localparam logic [CharW-1:0] CharComma = 8'h2c;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharNull  = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_DIV_START,
    S_DIV_WAIT,
    S_SIGN,
    S_FETCH,
    S_DIGIT,
    S_COMMA
  } ria_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } ria_div_sts_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {2'b00, d};
    if (d < DigitW'(10)) begin
      return CharZero + dx;
    end else begin
      return CharLowA + dx - CharW'(10);
    end
  endfunction

  function automatic logic [1:0] mod3_inc(input logic [1:0] m);
    case (m)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] mod3_dec(input logic [1:0] m);
    case (m)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

endpackage

// ----- rtl/ria_div.sv -----
// serial restoring divider, one quotient bit per cycle
module ria_div import ria_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RadixW-1:0]      divisor_i,
  output ria_div_sts_t           sts_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DigitW-1:0]      remainder_o
);

  localparam int CntW = $clog2(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DigitW-1:0]      rem_q, rem_d;
  logic [RadixW-1:0]      dvs_q, dvs_d;
  logic [DigitW:0]        trial;
  logic [DigitW:0]        diff;
  logic                   fits;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? diff[DigitW-1:0] : trial[DigitW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o       = '{busy: busy_q, done: done_q};
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/radix_integer_to_grouped_ascii.sv -----
// each digit is one division in the shared serial divider, through the div start and div wait states
// then the sign state, a send state per digit (after a fetch state for all but the first) and a comma state
// invalid radix: one flagged transaction, sent from the empty state through the output register
// next transaction accepted in the cycle after the last character enters the output register
// asynchronous active-low reset, radix register resets to 10
module radix_integer_to_grouped_ascii import ria_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth,
  parameter int MAX_DIGITS  = DefMaxDigits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [RadixW-1:0]             cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CharW-1:0]              character_o,
  output logic                          last_o,
  output logic                          empty_res_o
);

`include "radix_integer_to_grouped_ascii_defines.svh"

  localparam int CntW = $clog2(MAX_DIGITS + 1);
  localparam int IdxW = $clog2(MAX_DIGITS);

  ria_state_e state_q, state_d;

  logic [RadixW-1:0]      radix_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [CntW-1:0]        count_q;
  logic [1:0]             cnt3_q;
  logic [IdxW-1:0]        pos_q;
  logic [1:0]             pos3_q;
  logic [DigitW-1:0]      store_q [MAX_DIGITS];
  logic [DigitW-1:0]      rd_data_q;

  logic                   out_valid_q;
  logic [CharW-1:0]       char_q;
  logic                   last_q;
  logic                   empty_q;

  logic                   accept;
  logic                   out_free;
  logic                   radix_ok;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   store_we;
  logic                   emit;
  logic [CharW-1:0]       emit_char;
  logic                   emit_last;
  logic                   emit_empty;
  logic                   div_start;
  ria_div_sts_t           div_sts;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DigitW-1:0]      div_rem;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign radix_ok = (radix_q >= RadixMin) && (radix_q <= RadixMax);
  assign in_neg   = (radix_q == RadixDec) && value_i[VALUE_WIDTH-1];
  assign in_mag   = in_neg ? (VALUE_WIDTH'(0) - value_i) : value_i;
  assign store_we = (state_q == S_DIV_WAIT) && div_sts.done && (count_q < CntW'(MAX_DIGITS));

  ria_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (quo_q),
    .divisor_i  (radix_q),
    .sts_o      (div_sts),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = radix_ok ? S_DIV_START : S_EMPTY;
        end
      end
      S_EMPTY: begin
        if (out_free) state_d = S_IDLE;
      end
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_sts.done) begin
          state_d = (div_quo == '0) ? S_SIGN : S_DIV_START;
        end
      end
      S_SIGN: begin
        if (!neg_q || out_free) state_d = S_DIGIT;
      end
      S_FETCH: state_d = S_DIGIT;
      S_DIGIT: begin
        if (out_free) begin
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end else if (pos3_q == 2'd0) begin
            state_d = S_COMMA;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_COMMA: begin
        if (out_free) state_d = S_FETCH;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_char  = CharNull;
    emit_last  = 1'b0;
    emit_empty = 1'b0;
    case (state_q)
      S_IDLE:      in_ready_o = 1'b1;
      S_EMPTY: begin
        emit       = out_free;
        emit_last  = 1'b1;
        emit_empty = 1'b1;
      end
      S_DIV_START: div_start = 1'b1;
      S_SIGN: begin
        emit      = neg_q && out_free;
        emit_char = CharMinus;
      end
      S_DIGIT: begin
        emit      = out_free;
        emit_char = digit_char(rd_data_q);
        emit_last = (pos_q == '0);
      end
      S_COMMA: begin
        emit      = out_free;
        emit_char = CharComma;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RadixReset;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cnt3_q      <= '0;
      pos_q       <= '0;
      pos3_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) radix_q <= cfg_wdata_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        neg_q   <= in_neg;
        count_q <= '0;
        cnt3_q  <= '0;
      end
      if (store_we) begin
        pos_q   <= count_q[IdxW-1:0];
        pos3_q  <= cnt3_q;
        count_q <= count_q + CntW'(1);
        cnt3_q  <= mod3_inc(cnt3_q);
      end
      if ((state_q == S_DIGIT && out_free && pos_q != '0 && pos3_q != 2'd0) ||
          (state_q == S_COMMA && out_free)) begin
        pos_q  <= pos_q - IdxW'(1);
        pos3_q <= mod3_dec(pos3_q);
      end
    end
  end

  // quotient register, digit memory and output character register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      quo_q <= in_mag;
    end else if (state_q == S_DIV_WAIT && div_sts.done) begin
      quo_q <= div_quo;
    end
    if (store_we) begin
      store_q[count_q[IdxW-1:0]] <= div_rem;
    end
    rd_data_q <= store_q[pos_q];
    if (emit) begin
      char_q  <= emit_char;
      last_q  <= emit_last;
      empty_q <= emit_empty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

  `RIA_ASSERT(a_div_busy_in_wait, div_sts.busy |-> state_q == S_DIV_WAIT)
  `RIA_ASSERT(a_empty_is_single, (out_valid_o && empty_res_o) |-> (last_o && character_o == CharNull))
  `RIA_ASSERT_NEVER(a_count_bound, count_q > CntW'(MAX_DIGITS))
  `RIA_ASSERT(a_accept_next, accept |=> (state_q == S_EMPTY || state_q == S_DIV_START))

endmodule

// ----- sim/grouped_ascii_checker.sv -----
// checker for the grouped ascii converter: predicts the text of each value and compares
module grouped_ascii_checker import ria_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [31:0]       value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CharW-1:0]  character_i,
  input  logic              last_i,
  input  logic              empty_res_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int GroupSize    = 3;
  localparam int NumeralCount = 10;
  localparam int PrintCap     = 200;

  typedef struct packed {
    logic [CharW-1:0] glyph;
    logic             last;
    logic             empty;
  } text_char_t;

  text_char_t        expected_text[$];
  text_char_t        oldest;
  logic [RadixW-1:0] base;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < PrintCap) begin
      $display("mismatch in %s: got 'h%0h, expected 'h%0h", what, got, want);
    end
    fail_count_o++;
  endtask

  function automatic void push_char(input logic [CharW-1:0] g, input logic l, input logic e);
    text_char_t c;
    c.glyph = g;
    c.last  = l;
    c.empty = e;
    expected_text.push_back(c);
  endfunction

  // digits least significant first, then emitted most significant first with commas
  function automatic void format_grouped_text(input logic [31:0] v, input logic [RadixW-1:0] b);
    logic [DigitW-1:0] digs[32];
    logic [31:0]       mag;
    logic [CharW-1:0]  g;
    logic              neg;
    int                n;
    if (b < RadixMin || b > RadixMax) begin
      push_char(CharNull, 1'b1, 1'b1);
      return;
    end
    neg = (b == RadixDec) && v[31];
    mag = neg ? (32'd0 - v) : v;
    n = 0;
    do begin
      digs[n] = DigitW'(mag % b);
      mag = mag / b;
      n++;
    end while (mag != 0);
    if (neg) begin
      push_char(CharMinus, 1'b0, 1'b0);
    end
    for (int p = n - 1; p >= 0; p--) begin
      if (digs[p] < NumeralCount) begin
        g = CharZero + CharW'(digs[p]);
      end else begin
        g = CharLowA + CharW'(digs[p]) - CharW'(NumeralCount);
      end
      push_char(g, p == 0, 1'b0);
      if (p != 0 && (p % GroupSize) == 0) begin
        push_char(CharComma, 1'b0, 1'b0);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base = RadixReset;
      expected_text.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        format_grouped_text(value_i, base);
      end
      if (cfg_we_i) begin
        base = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected character", 32'(character_i), 32'd0);
        end else begin
          oldest = expected_text.pop_front();
          if (character_i !== oldest.glyph) begin
            report_mismatch("character", 32'(character_i), 32'(oldest.glyph));
          end
          if (last_i !== oldest.last) begin
            report_mismatch("last", 32'(last_i), 32'(oldest.last));
          end
          if (empty_res_i !== oldest.empty) begin
            report_mismatch("empty_res", 32'(empty_res_i), 32'(oldest.empty));
          end
        end
      end
      pending_o = expected_text.size();
    end
  end

endmodule

// ----- sim/radix_integer_to_grouped_ascii_test.sv -----
// testbench top for the grouped ascii converter: stimulus, flow control and verdict
module radix_integer_to_grouped_ascii_test;
  import ria_pkg::*;

  localparam int          MaxGap      = 17;
  localparam int          PhaseCount  = 14;
  localparam int          PhaseItems  = 20;
  localparam int          DrainTail   = 50;
  localparam int unsigned CycleLimit  = 4_000_000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RadixW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [31:0]       value;
  logic              out_valid;
  logic              out_ready;
  logic [CharW-1:0]  character;
  logic              last;
  logic              empty_res;

  int          fail_count;
  int          pending;
  logic        calm;
  int          rx_gap;
  int          rx_hold;
  int unsigned cycle_count = 0;
  logic [RadixW-1:0] cur_base;

  radix_integer_to_grouped_ascii i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .character_o (character),
    .last_o      (last),
    .empty_res_o (empty_res)
  );

  grouped_ascii_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .character_i  (character),
    .last_i       (last),
    .empty_res_i  (empty_res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls for a random pause after each transaction, except in calm phases
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      rx_gap = calm ? 0 : $urandom_range(0, MaxGap);
      rx_hold <= rx_gap;
      out_ready <= (rx_gap == 0);
    end else if (!out_ready) begin
      if (rx_hold <= 1) begin
        out_ready <= 1'b1;
      end
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_radix(input logic [RadixW-1:0] r);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    cur_base = r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RadixW-1:0] pick_radix();
    case ($urandom_range(0, 9))
      6, 7:    return RadixDec;
      8:       return $urandom_range(0, 1) ? RadixW'($urandom_range(0, 1))
                                           : RadixW'($urandom_range(37, 63));
      9:       return $urandom_range(0, 1) ? RadixMin : RadixMax;
      default: return RadixW'($urandom_range(RadixMin, RadixMax));
    endcase
  endfunction

  // mixes full-range, small, negative, power-of-base, extreme and randomly shifted values
  function automatic logic [31:0] pick_value(input logic [RadixW-1:0] b);
    logic [63:0] p;
    int          k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: return 32'd0 - $urandom_range(1, 99999);
      3: begin
        if (b < RadixMin) return $urandom;
        p = 64'd1;
        k = $urandom_range(1, 32);
        repeat (k) if (p * b < 64'h1_0000_0000) p = p * b;
        return 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
      end
      4: case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0000;
        default: return 32'hffff_ffff;
      endcase
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decimal: zero, sign, group boundaries, largest and most negative
    set_radix(RadixDec);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd999);
    send_value(32'd1000);
    send_value(-32'sd1000);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd123456789);

    // binary: longest text
    set_radix(RadixMin);
    send_value(32'd0);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd5);

    // base 36: letters up to z
    set_radix(RadixMax);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);

    set_radix(6'd16);
    send_value(32'hdead_beef);

    // out of range bases
    set_radix(6'd0);
    send_value(32'd7);
    set_radix(6'd1);
    send_value(32'd7);
    set_radix(6'd37);
    send_value(32'd1);
    set_radix(6'd63);
    send_value(32'hffff_ffff);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_radix(pick_radix());
      calm = ($urandom_range(0, 3) == 0);
      for (int it = 0; it < PhaseItems; it++) begin
        if ($urandom_range(0, 19) == 0) wait_drained();
        send_value(pick_value(cur_base));
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainTail) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ria_pkg.sv
rtl/ria_div.sv
rtl/radix_integer_to_grouped_ascii.sv
sim/grouped_ascii_checker.sv
sim/radix_integer_to_grouped_ascii_test.sv
